@@ design/htsd_pkg.sv @@
// package for the huffman tree stream decoder
// holds sizes, marker codes, error codes and the node and pending-stack record types
`default_nettype none
package htsd_pkg;
    localparam int MAX_NODES   = 512;
    localparam int STACK_DEPTH = 256;
    localparam int NIDX_W = $clog2(MAX_NODES);
    localparam int NCNT_W = $clog2(MAX_NODES + 1);
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int SCNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] MARK_INTERNAL = 8'h30;
    localparam logic [7:0] MARK_LEAF     = 8'h31;
    localparam logic [2:0] TOP_BIT       = 3'd7;

    // register byte addresses
    localparam logic [1:0] REG_ORIG_LEN = 2'd0;

    // parse phases
    localparam logic [1:0] PH_MARKER = 2'd0;
    localparam logic [1:0] PH_SYMBOL = 2'd1;
    localparam logic [1:0] PH_DECODE = 2'd2;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_MARKER   = 2'd1,
        ERR_MISSING  = 2'd2,
        ERR_OVERFLOW = 2'd3
    } err_t;

    typedef struct packed {
        logic              leaf;
        logic [7:0]        sym;
        logic [NIDX_W-1:0] left;
        logic [NIDX_W-1:0] right;
    } node_t;

    typedef struct packed {
        logic [NIDX_W-1:0] idx;
        logic              left_done;
    } pend_t;
endpackage
`default_nettype wire

@@ design/huffman_tree_stream_decoder_core.sv @@
// huffman decoder core: preorder tree header parse, then bit-serial tree walk
// depends on htsd_pkg
`default_nettype none
// Each input byte is parsed or decoded by a small sequencer around the node table.
// A leaf marker byte is taken in idle; other tree-header bytes pass node write,
// parent link when a parent is pending, and the push step. A code byte walks its
// bits from the top: a registered read of the child chosen by the bit, then a step
// on it, after a root read where the bit before ended at a leaf; a flush then
// releases the held last result. Output steps stall on m_tready. One symbol is held
// back until the next symbol or the end of the byte shows whether it is the last
// one. s_tready is low while a byte is being worked or a result waits.
// start_of_stream (tuser) clears the tree and counters before its byte;
// original_length at address 0 limits the number of symbols, 0 meaning unlimited.
// Errors give one result and halt the block until the next start_of_stream. No clearing pass after reset.
module huffman_tree_stream_decoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // byte_value
    input  wire logic        s_tuser,   // start_of_stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // symbol[7:0], stream_done[8], error_code[10:9], 0
    output logic             m_tlast,   // last_of_run
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import htsd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PREP  = 8'b0000_0010,
        S_LINK  = 8'b0000_0100,
        S_PUSH  = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_STEP  = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } state_t;

    // memories
    node_t node_mem [MAX_NODES];
    pend_t pend_mem [STACK_DEPTH];

    state_t            state_reg, state_next;
    logic [31:0]       len_reg;
    logic [NCNT_W-1:0] ncount_reg, ncount_next;
    logic [SCNT_W-1:0] sp_reg, sp_next;
    logic [1:0]        phase_reg, phase_next;
    logic [NIDX_W-1:0] walk_reg, walk_next;
    logic [31:0]       emitted_reg, emitted_next;
    logic              halted_reg, halted_next;
    logic [7:0]        byte_reg, byte_next;
    logic [2:0]        bit_reg, bit_next;
    logic              leafnew_reg, leafnew_next;
    logic              root_leaf_reg, root_leaf_next;
    logic              ov_valid_reg, ov_valid_next;
    logic [7:0]        ov_sym_reg, ov_sym_next;
    logic              ov_done_reg, ov_done_next;
    logic [1:0]        ov_err_reg, ov_err_next;
    logic              ov_last_reg, ov_last_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [7:0]        hold_sym_reg, hold_sym_next;
    logic              hold_done_reg, hold_done_next;

    // memory port controls
    logic              nwr_en, nrd_en;
    logic [NIDX_W-1:0] nwr_addr, nrd_addr;
    node_t             nwr_data, nrd_data;
    logic              swr_en;
    logic [SIDX_W-1:0] swr_addr, srd_addr;
    pend_t             swr_data, srd_data;

    logic accept;
    logic done_now;
    logic [31:0] emit_inc;
    logic [NIDX_W-1:0] nxt_idx;
    logic [NIDX_W-1:0] new_idx;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !ov_valid_reg;
    assign pready   = 1'b1;
    assign prdata   = len_reg;
    assign new_idx  = ncount_reg[NIDX_W-1:0];
    assign emit_inc = (emitted_reg != 32'hFFFF_FFFF) ? emitted_reg + 32'd1 : emitted_reg;
    assign done_now = (len_reg != 32'd0) && (emit_inc >= len_reg);
    assign nxt_idx  = byte_reg[bit_reg] ? nrd_data.right : nrd_data.left;

    assign m_tvalid = ov_valid_reg;
    assign m_tlast  = ov_last_reg;
    assign m_tdata  = {5'd0, ov_err_reg, ov_done_reg, ov_sym_reg};

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr == REG_ORIG_LEN) begin
            len_reg <= pwdata;
        end
    end

    // node table, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (nwr_en) begin
            node_mem[nwr_addr] <= nwr_data;
        end
        if (nrd_en) begin
            nrd_data <= node_mem[nrd_addr];
        end
    end

    // pending stack
    always_ff @(posedge aclk) begin
        if (swr_en) begin
            pend_mem[swr_addr] <= swr_data;
        end
        srd_data <= pend_mem[srd_addr];
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        ncount_next     = ncount_reg;
        sp_next         = sp_reg;
        phase_next      = phase_reg;
        walk_next       = walk_reg;
        emitted_next    = emitted_reg;
        halted_next     = halted_reg;
        byte_next       = byte_reg;
        bit_next        = bit_reg;
        leafnew_next    = leafnew_reg;
        root_leaf_next  = root_leaf_reg;
        ov_valid_next   = ov_valid_reg;
        ov_sym_next     = ov_sym_reg;
        ov_done_next    = ov_done_reg;
        ov_err_next     = ov_err_reg;
        ov_last_next    = ov_last_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        hold_done_next  = hold_done_reg;
        nwr_en   = 1'b0;
        nwr_addr = new_idx;
        nwr_data = '0;
        nrd_en   = 1'b0;
        nrd_addr = walk_reg;
        swr_en   = 1'b0;
        swr_addr = '0;
        swr_data = '0;
        srd_addr = SIDX_W'(sp_reg - SCNT_W'(1));

        if (ov_valid_reg && m_tready) begin
            ov_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    logic h;
                    logic [1:0] ph;
                    h  = halted_reg;
                    ph = phase_reg;
                    byte_next = s_tdata;
                    if (s_tuser) begin
                        ncount_next = '0;
                        sp_next = '0;
                        ph = PH_MARKER;
                        phase_next = PH_MARKER;
                        walk_next = '0;
                        emitted_next = '0;
                        h = 1'b0;
                        halted_next = 1'b0;
                    end
                    if (!h) begin
                        priority if (ph == PH_MARKER) begin
                            if (s_tdata == MARK_INTERNAL) begin
                                leafnew_next = 1'b0;
                                state_next = S_PREP;
                            end else if (s_tdata == MARK_LEAF) begin
                                phase_next = PH_SYMBOL;
                            end else begin
                                halted_next = 1'b1;
                                ov_valid_next = 1'b1;
                                ov_sym_next = '0; ov_done_next = 1'b0;
                                ov_err_next = ERR_MARKER; ov_last_next = 1'b1;
                            end
                        end else if (ph == PH_SYMBOL) begin
                            leafnew_next = 1'b1;
                            state_next = S_PREP;
                        end else begin
                            if ((len_reg != 32'd0) && (emitted_reg >= len_reg)) begin
                                state_next = S_IDLE;
                            end else if (root_leaf_reg) begin
                                halted_next = 1'b1;
                                ov_valid_next = 1'b1;
                                ov_sym_next = '0; ov_done_next = 1'b0;
                                ov_err_next = ERR_MISSING; ov_last_next = 1'b1;
                            end else begin
                                bit_next = TOP_BIT;
                                state_next = S_READ;
                            end
                        end
                    end
                end
            end
            // store the node; stack top read is now valid
            S_PREP: begin
                if (ncount_reg >= NCNT_W'(MAX_NODES)) begin
                    halted_next = 1'b1;
                    ov_valid_next = 1'b1;
                    ov_sym_next = '0; ov_done_next = 1'b0;
                    ov_err_next = ERR_OVERFLOW; ov_last_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    nwr_en = 1'b1;
                    nwr_data.leaf = leafnew_reg;
                    nwr_data.sym  = leafnew_reg ? byte_reg : 8'd0;
                    if (ncount_reg == '0) begin
                        root_leaf_next = leafnew_reg;
                    end
                    ncount_next = ncount_reg + NCNT_W'(1);
                    // read parent node for link update
                    nrd_en = 1'b1;
                    nrd_addr = srd_data.idx;
                    state_next = (sp_reg != '0) ? S_LINK : S_PUSH;
                end
            end
            // link child into parent, pop if right side filled
            S_LINK: begin
                nwr_en = 1'b1;
                nwr_addr = srd_data.idx;
                nwr_data = nrd_data;
                if (!srd_data.left_done) begin
                    nwr_data.left = NIDX_W'(ncount_reg - NCNT_W'(1));
                    swr_en = 1'b1;
                    swr_addr = SIDX_W'(sp_reg - SCNT_W'(1));
                    swr_data = '{idx: srd_data.idx, left_done: 1'b1};
                end else begin
                    nwr_data.right = NIDX_W'(ncount_reg - NCNT_W'(1));
                    sp_next = sp_reg - SCNT_W'(1);
                end
                state_next = S_PUSH;
            end
            S_PUSH: begin
                logic [SCNT_W-1:0] sp;
                sp = sp_reg;
                state_next = S_IDLE;
                if (!leafnew_reg) begin
                    if (sp >= SCNT_W'(STACK_DEPTH)) begin
                        halted_next = 1'b1;
                        ov_valid_next = 1'b1;
                        ov_sym_next = '0; ov_done_next = 1'b0;
                        ov_err_next = ERR_OVERFLOW; ov_last_next = 1'b1;
                    end else begin
                        swr_en = 1'b1;
                        swr_addr = SIDX_W'(sp);
                        swr_data = '{idx: NIDX_W'(ncount_reg - NCNT_W'(1)), left_done: 1'b0};
                        sp = sp + SCNT_W'(1);
                        sp_next = sp;
                    end
                end
                if (!halted_next) begin
                    if (sp == '0) begin
                        phase_next = PH_DECODE;
                        walk_next = '0;
                    end else begin
                        phase_next = PH_MARKER;
                    end
                end
            end
            // read current walk node
            S_READ: begin
                nrd_en = 1'b1;
                nrd_addr = walk_reg;
                state_next = S_STEP;
            end
            // read the child chosen by the bit
            S_STEP: begin
                nrd_en = 1'b1;
                nrd_addr = nxt_idx;
                walk_next = nxt_idx;
                state_next = S_EMIT;
            end
            // child is in nrd_data: leaf is held, the one held before goes out
            S_EMIT: begin
                if (!ov_valid_reg || m_tready) begin
                    logic fin;
                    fin = (bit_reg == 3'd0);
                    if (nrd_data.leaf) begin
                        // a later symbol exists, so the held one is not last
                        if (hold_valid_reg) begin
                            ov_valid_next = 1'b1;
                            ov_sym_next = hold_sym_reg;
                            ov_done_next = hold_done_reg;
                            ov_err_next = ERR_NONE;
                            ov_last_next = 1'b0;
                        end
                        emitted_next = emit_inc;
                        walk_next = '0;
                        hold_valid_next = 1'b1;
                        hold_sym_next = nrd_data.sym;
                        hold_done_next = done_now;
                        fin = fin || done_now;
                    end
                    bit_next = bit_reg - 3'd1;
                    state_next = fin ? S_FLUSH : (nrd_data.leaf ? S_READ : S_STEP);
                    // non-leaf: current node already in nrd_data
                end
            end
            // end of byte: the held symbol goes out as the last one
            S_FLUSH: begin
                if (!hold_valid_reg) begin
                    state_next = S_IDLE;
                end else if (!ov_valid_reg || m_tready) begin
                    ov_valid_next = 1'b1;
                    ov_sym_next = hold_sym_reg;
                    ov_done_next = hold_done_reg;
                    ov_err_next = ERR_NONE;
                    ov_last_next = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ncount_reg     <= '0;
            sp_reg         <= '0;
            phase_reg      <= PH_MARKER;
            walk_reg       <= '0;
            emitted_reg    <= '0;
            halted_reg     <= 1'b0;
            ov_valid_reg   <= 1'b0;
            root_leaf_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ncount_reg     <= ncount_next;
            sp_reg         <= sp_next;
            phase_reg      <= phase_next;
            walk_reg       <= walk_next;
            emitted_reg    <= emitted_next;
            halted_reg     <= halted_next;
            ov_valid_reg   <= ov_valid_next;
            root_leaf_reg  <= root_leaf_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        bit_reg       <= bit_next;
        leafnew_reg   <= leafnew_next;
        ov_sym_reg    <= ov_sym_next;
        ov_done_reg   <= ov_done_next;
        ov_err_reg    <= ov_err_next;
        ov_last_reg   <= ov_last_next;
        hold_sym_reg  <= hold_sym_next;
        hold_done_reg <= hold_done_next;
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SCNT_W'(STACK_DEPTH)) else $error("stack pointer out of range");
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && err_t'(m_tdata[10:9]) != ERR_NONE |-> m_tlast)
        else $error("error not last");
`endif
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// testbench for huffman_tree_stream_decoder_core: random and directed byte streams
// predicts decoded symbols in an internal tree model; depends on htsd_pkg and the core
`timescale 1ns / 1ps
module testbench;
    import htsd_pkg::*;

    localparam int          WDOG_LIMIT   = 4000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 40;

    typedef struct {
        logic [7:0] sym;
        logic       done;
        err_t       err;
        logic       last;
    } sym_rec_t;

    typedef struct {
        logic [7:0] data;
        logic       sos;
        logic       typed;
        err_t       err;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // side info that travels with a directed item
    logic        cur_typed = 1'b0;
    err_t        cur_err = ERR_NONE;

    huffman_tree_stream_decoder_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decoder model state
    logic       tr_leaf [MAX_NODES];
    logic [7:0] tr_sym [MAX_NODES];
    int         tr_left [MAX_NODES];
    int         tr_right [MAX_NODES];
    int         pend_idx [STACK_DEPTH];
    logic       pend_ldone [STACK_DEPTH];
    int         n_nodes, sp, walk;
    logic [1:0] phase;
    logic [31:0] sym_count, len_limit;
    logic       stopped;

    sym_rec_t   symbol_q[$];
    int         n_fail = 0;
    int         tx_max = 10, rx_max = 10;
    logic       hold_req = 1'b0;
    logic [7:0] hdr_q[$];

    function automatic void push_fail(err_t e);
        sym_rec_t r;
        stopped = 1'b1;
        r.sym = 8'd0; r.done = 1'b0; r.err = e; r.last = 1'b1;
        symbol_q.insert(symbol_q.size(), r);
    endfunction

    // returns 1 on overflow
    function automatic bit add_node(logic leaf, logic [7:0] s);
        int idx;
        idx = n_nodes;
        if (idx >= MAX_NODES) return 1'b1;
        tr_leaf[idx] = leaf;
        tr_sym[idx] = leaf ? s : 8'd0;
        tr_left[idx] = 0;
        tr_right[idx] = 0;
        n_nodes = idx + 1;
        if (sp > 0) begin
            if (!pend_ldone[sp-1]) begin
                tr_left[pend_idx[sp-1]] = idx;
                pend_ldone[sp-1] = 1'b1;
            end else begin
                tr_right[pend_idx[sp-1]] = idx;
                sp--;
            end
        end
        if (!leaf) begin
            if (sp >= STACK_DEPTH) return 1'b1;
            pend_idx[sp] = idx;
            pend_ldone[sp] = 1'b0;
            sp++;
        end
        if (sp == 0) begin
            phase = PH_DECODE;
            walk = 0;
        end else begin
            phase = PH_MARKER;
        end
        return 1'b0;
    endfunction

    // works out the symbols that one stream byte yields
    function automatic void decode_byte(logic [7:0] b, logic sos);
        sym_rec_t r;
        int nxt, nres;
        nres = 0;
        if (sos) begin
            n_nodes = 0; sp = 0; phase = PH_MARKER; walk = 0; sym_count = 0;
            stopped = 1'b0;
        end
        if (stopped) return;
        if (phase == PH_MARKER) begin
            if (b == MARK_INTERNAL) begin
                if (add_node(1'b0, 8'd0)) push_fail(ERR_OVERFLOW);
            end else if (b == MARK_LEAF) begin
                phase = PH_SYMBOL;
            end else begin
                push_fail(ERR_MARKER);
            end
            return;
        end
        if (phase == PH_SYMBOL) begin
            if (add_node(1'b1, b)) push_fail(ERR_OVERFLOW);
            return;
        end
        if (len_limit != 0 && sym_count >= len_limit) return;
        if (tr_leaf[0]) begin
            push_fail(ERR_MISSING);
            return;
        end
        for (int i = 7; i >= 0; i--) begin
            nxt = b[i] ? tr_right[walk] : tr_left[walk];
            if (tr_leaf[nxt]) begin
                if (sym_count != 32'hFFFF_FFFF) sym_count++;
                r.sym = tr_sym[nxt];
                r.done = (len_limit != 0 && sym_count >= len_limit);
                r.err = ERR_NONE;
                r.last = 1'b0;
                symbol_q.insert(symbol_q.size(), r);
                nres++;
                walk = 0;
                if (r.done) break;
            end else begin
                walk = nxt;
            end
        end
        if (nres > 0) symbol_q[$].last = 1'b1;
    endfunction

    // prediction on accepted items, checking of accepted results
    always @(posedge aclk) begin
        sym_rec_t e;
        int n0;
        if (aresetn && psel && penable && pwrite && pready && paddr == REG_ORIG_LEN)
            len_limit = pwdata;
        if (aresetn && s_tvalid && s_tready) begin
            n0 = symbol_q.size();
            decode_byte(s_tdata, s_tuser);
            if (cur_typed) begin
                while (symbol_q.size() > n0) void'(symbol_q.pop_back());
                e.sym = 8'd0; e.done = 1'b0; e.err = cur_err; e.last = 1'b1;
                symbol_q.insert(symbol_q.size(), e);
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (symbol_q.size() == 0) begin
                $display("%0t: unexpected item, actual sym=%h done=%b err=%0d last=%b",
                         $time, m_tdata[7:0], m_tdata[8], m_tdata[10:9], m_tlast);
                n_fail++;
            end else begin
                e = symbol_q.pop_front();
                if (m_tdata[7:0] !== e.sym || m_tdata[8] !== e.done ||
                    m_tdata[10:9] !== e.err || m_tlast !== e.last) begin
                    $display("%0t: mismatch, expected sym=%h done=%b err=%0d last=%b",
                             $time, e.sym, e.done, e.err, e.last);
                    $display("%0t:           actual   sym=%h done=%b err=%0d last=%b",
                             $time, m_tdata[7:0], m_tdata[8], m_tdata[10:9], m_tlast);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        int idle_cnt;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("FAIL huffman_tree_stream_decoder_core");
            $finish;
        end
    end

    // result side: random stalls and one long hold-off
    initial begin
        int w;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            w = $urandom_range(0, rx_max);
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_byte(logic [7:0] b, logic sos, logic typed = 1'b0,
                             err_t e = ERR_NONE);
        int g;
        g = $urandom_range(0, tx_max);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= sos;
        cur_typed <= typed;
        cur_err <= e;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (symbol_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_len(logic [31:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_ORIG_LEN; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // random full binary tree in preorder form
    function automatic void build_tree(int leaves);
        int k;
        if (leaves == 1) begin
            hdr_q.insert(hdr_q.size(), MARK_LEAF);
            hdr_q.insert(hdr_q.size(), 8'($urandom));
        end else begin
            hdr_q.insert(hdr_q.size(), MARK_INTERNAL);
            k = $urandom_range(1, leaves - 1);
            build_tree(k);
            build_tree(leaves - k);
        end
    endfunction

    task automatic send_stream(int kind);
        int ncode;
        hdr_q.delete();
        case (kind)
            0: begin
                build_tree($urandom_range(2, 12));
            end
            1: begin
                // truncated or corrupted header
                build_tree($urandom_range(2, 8));
                hdr_q = hdr_q[0:$urandom_range(0, hdr_q.size() - 1)];
                if ($urandom_range(0, 1)) hdr_q.insert(hdr_q.size(), 8'($urandom));
            end
            default: begin
                // single leaf tree
                hdr_q.insert(hdr_q.size(), MARK_LEAF);
                hdr_q.insert(hdr_q.size(), 8'($urandom));
            end
        endcase
        foreach (hdr_q[i]) send_byte(hdr_q[i], i == 0);
        ncode = $urandom_range(2, 10);
        repeat (ncode) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic random_phase(int n_items);
        int r;
        repeat (n_items / 8) begin
            r = $urandom_range(0, 9);
            send_stream(r < 8 ? 0 : (r == 8 ? 1 : 2));
        end
    endtask

    row_t dir_rows[$] = '{
        '{MARK_INTERNAL, 1'b1, 1'b0, ERR_NONE},
        '{MARK_LEAF,     1'b0, 1'b0, ERR_NONE},
        '{8'h00,         1'b0, 1'b0, ERR_NONE},
        '{MARK_LEAF,     1'b0, 1'b0, ERR_NONE},
        '{8'hFF,         1'b0, 1'b0, ERR_NONE},
        '{8'h00,         1'b0, 1'b0, ERR_NONE},
        '{8'hFF,         1'b0, 1'b0, ERR_NONE},
        '{8'hA5,         1'b0, 1'b0, ERR_NONE},
        '{8'h7F,         1'b1, 1'b1, ERR_MARKER},
        '{MARK_INTERNAL, 1'b0, 1'b0, ERR_NONE},
        '{MARK_LEAF,     1'b1, 1'b0, ERR_NONE},
        '{8'h42,         1'b0, 1'b0, ERR_NONE},
        '{8'h80,         1'b0, 1'b1, ERR_MISSING},
        '{MARK_INTERNAL, 1'b1, 1'b0, ERR_NONE},
        '{MARK_INTERNAL, 1'b0, 1'b0, ERR_NONE},
        '{MARK_LEAF,     1'b0, 1'b0, ERR_NONE},
        '{8'hFF,         1'b0, 1'b0, ERR_NONE},
        '{MARK_LEAF,     1'b0, 1'b0, ERR_NONE},
        '{8'h01,         1'b0, 1'b0, ERR_NONE},
        '{MARK_LEAF,     1'b0, 1'b0, ERR_NONE},
        '{8'h80,         1'b0, 1'b0, ERR_NONE},
        '{8'h5A,         1'b0, 1'b0, ERR_NONE},
        '{8'h00,         1'b0, 1'b0, ERR_NONE}
    };

    logic [31:0] len_set[6] = '{32'd0, 32'd1, 32'd7, 32'hFFFF_FFFF, 32'd0, 32'd0};

    initial begin
        len_limit = '0;
        n_nodes = 0; sp = 0; phase = PH_MARKER; walk = 0; sym_count = '0; stopped = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset setting
        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].sos, dir_rows[i].typed, dir_rows[i].err);
        wait_idle();

        len_set[4] = $urandom_range(2, 40);
        for (int p = 0; p < 6; p++) begin
            write_len(len_set[p]);
            if (p == 1) begin
                tx_max = 0;
                rx_max = 0;
            end else begin
                tx_max = 10;
                rx_max = 10;
            end
            random_phase(16);
            if (p == 5) begin
                // long receiver hold-off while the sender keeps offering items
                build_tree(4);
                hdr_q.delete();
                build_tree(3);
                foreach (hdr_q[i]) send_byte(hdr_q[i], i == 0);
                hold_req = 1'b1;
                tx_max = 0;
                repeat (12) send_byte(8'($urandom), 1'b0);
                // sender pause until all symbols are out
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (symbol_q.size() != 0) @(posedge aclk);
                repeat (6) send_byte(8'($urandom), 1'b0);
            end
            wait_idle();
        end

        if (n_fail == 0)
            $display("PASS huffman_tree_stream_decoder_core");
        else
            $display("FAIL huffman_tree_stream_decoder_core");
        $finish;
    end
endmodule
